### rtl/core/rsmv_pkg.sv
// Shared types and constants of the rate set statistics block.
`timescale 1ns / 1ps
package rsmv_pkg;

	localparam int RATE_W = 24;
	localparam int FRAC_W = 16;
	localparam int CNT_W  = 7;
	localparam int CFG_W  = 24;

	localparam logic REG_PEER_COUNT = 1'b0;
	localparam logic REG_RATE_FLOOR = 1'b1;

	localparam logic [CNT_W-1:0]  PEER_COUNT_RST = 7'd3;
	localparam logic [RATE_W-1:0] RATE_FLOOR_RST = 24'd10;

	typedef struct packed {
		logic [RATE_W-1:0] upload_rate;
		logic [RATE_W-1:0] download_rate;
		logic              last_item;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] median_upload;
		logic [RATE_W-1:0] median_download;
		logic [RATE_W-1:0] median_ratio;
		logic [RATE_W-1:0] variation;
		logic              variation_valid;
		logic [CNT_W-1:0]  item_count;
		logic              set_ready;
	} out_item_t;

endpackage

### rtl/core/rsmv_if.sv
// Valid/ready channel interfaces for measurement and result words.
`timescale 1ns / 1ps
interface rsmv_in_if;
	logic               valid;
	logic               ready;
	rsmv_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rsmv_out_if;
	logic                valid;
	logic                ready;
	rsmv_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/rsmv_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
`timescale 1ns / 1ps
module rsmv_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NW-1:0]               num,
	input  logic [DW-1:0]               den,
	output logic                        done,
	output logic [rsmv_pkg::RATE_W-1:0] quo
);
	localparam int QW = rsmv_pkg::RATE_W;
	localparam int LW = (NW > DW + QW) ? NW : DW + QW;
	localparam int SW = $clog2(QW);

	logic          active_q;
	logic          done_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] dsh_q;
	logic [SW-1:0] step_q;
	logic [QW-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// quotient would not fit: saturate at once
				if (LW'(num) >= (LW'(den) << QW)) begin
					quo_q  <= '1;
					done_q <= 1'b1;
				end else begin
					rem_q    <= LW'(num);
					dsh_q    <= LW'(den) << (QW - 1);
					step_q   <= SW'(QW - 1);
					quo_q    <= '0;
					active_q <= 1'b1;
				end
			end else if (active_q) begin
				if (rem_q >= dsh_q) begin
					rem_q         <= rem_q - dsh_q;
					quo_q[step_q] <= 1'b1;
				end
				dsh_q <= dsh_q >> 1;
				if (step_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/rsmv_sqrt.sv
// Digit-by-digit integer square root of the operand scaled by 2^32, one bit per cycle.
`timescale 1ns / 1ps
module rsmv_sqrt #(
	parameter int VW = 62
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [VW-1:0]                              val,
	output logic                                       done,
	output logic [(VW+2*rsmv_pkg::FRAC_W)/2-1:0]      root
);
	localparam int RW = (VW + 2 * rsmv_pkg::FRAC_W) / 2;
	localparam int XW = 2 * RW;
	localparam int SW = $clog2(RW);

	logic          active_q;
	logic          done_q;
	logic [XW-1:0] x_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [SW-1:0] step_q;
	logic [RW+1:0] r2;
	logic [RW+1:0] trial;

	assign r2    = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q      <= XW'({val, {(2 * rsmv_pkg::FRAC_W){1'b0}}});
				rem_q    <= '0;
				root_q   <= '0;
				step_q   <= SW'(RW - 1);
				active_q <= 1'b1;
			end else if (active_q) begin
				if (r2 >= trial) begin
					rem_q  <= r2 - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= r2;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				x_q <= x_q << 2;
				if (step_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/rate_set_median_and_variation.sv
// Top level: measurement store, statistics sequencer and result register.
`timescale 1ns / 1ps
// Loads one upload/download word per cycle into the stores (words beyond MAX_ITEMS are
// dropped); the word marked last starts a computation during which no word is taken.
// For n held words it finds three medians by rank counting and runs a pairwise variance
// sweep, all set by the single read port of the stores; each ratio goes through the
// shared bit-serial divider, and the root through the bit-serial square root. The
// result waits in an output register; loading resumes as soon as it is there.
module rate_set_median_and_variation #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rsmv_in_if.sink                    in_ch,
	rsmv_out_if.source                 out_ch,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [rsmv_pkg::CFG_W-1:0] wr_data
);
	localparam int RTW = rsmv_pkg::RATE_W;
	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int S1W = RTW + CW;
	localparam int VW  = 2 * RTW + 2 * CW;
	localparam int RW  = (VW + 2 * rsmv_pkg::FRAC_W) / 2;

	typedef enum logic [4:0] {
		S_IDLE, S_R_RD, S_R_CHK, S_R_WAIT, S_M_CAND, S_M_CLOAD, S_M_RD, S_M_CMP,
		S_V_RD, S_V_ADD, S_V_CHK, S_P_I, S_P_ILOAD, S_P_RD, S_P_MUL, S_P_ACC,
		S_SQ_WAIT, S_DV_WAIT, S_DONE
	} state_t;

	typedef enum logic [1:0] {SEL_UP, SEL_DN, SEL_RT} sel_t;

	state_t state_q;
	sel_t   sel_q;

	logic [rsmv_pkg::CNT_W-1:0] peer_count_q;
	logic [RTW-1:0]             floor_q;

	logic [RTW-1:0] up_mem [MAX_ITEMS];
	logic [RTW-1:0] dn_mem [MAX_ITEMS];
	logic [RTW-1:0] rt_mem [MAX_ITEMS];
	logic [RTW-1:0] up_rd_q, dn_rd_q, rt_rd_q, rd_sel;
	logic [AW-1:0]  rd_addr;

	logic [CW-1:0]  cnt_q, n_q, k_q, i_q, j_q, len_q, lt_q, le_q;
	logic [CW-1:0]  k1, k2;
	logic [RTW-1:0] x_q, lo_q, hi_q, med;
	logic [RTW-1:0] res_up_q, res_dn_q, res_rt_q, res_var_q;
	logic [RTW-1:0] diff;
	logic [2*RTW-1:0] prod_q;
	logic [S1W-1:0] s1_q, floor_n;
	logic [VW-1:0]  vsum_q;

	rsmv_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic accept, load_we, rt_we, can_load;
	logic div_start, div_done, sq_start, sq_done;
	logic [RW-1:0]  div_num, sq_root;
	logic [S1W-1:0] div_den;
	logic [RTW-1:0] div_quo;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign load_we     = accept && (cnt_q < CW'(MAX_ITEMS));
	assign rt_we       = (state_q == S_R_WAIT) && div_done;
	assign can_load    = !out_valid_q || out_ch.ready;

	assign rd_addr = (state_q == S_M_RD || state_q == S_P_RD) ? j_q[AW-1:0] : i_q[AW-1:0];

	always_comb begin
		case (sel_q)
			SEL_UP:  rd_sel = up_rd_q;
			SEL_DN:  rd_sel = dn_rd_q;
			default: rd_sel = rt_rd_q;
		endcase
	end

	assign k1      = (len_q - 1'b1) >> 1;
	assign k2      = len_q >> 1;
	assign med     = RTW'(((RTW + 1)'(lo_q) + (RTW + 1)'(hi_q)) >> 1);
	assign diff    = (x_q > dn_rd_q) ? x_q - dn_rd_q : dn_rd_q - x_q;
	assign floor_n = S1W'(floor_q) * S1W'(n_q);

	assign div_start = ((state_q == S_R_CHK) && (dn_rd_q > floor_q))
		|| ((state_q == S_SQ_WAIT) && sq_done);
	assign div_num   = (state_q == S_R_CHK) ? RW'({up_rd_q, {rsmv_pkg::FRAC_W{1'b0}}}) : sq_root;
	assign div_den   = (state_q == S_R_CHK) ? S1W'(dn_rd_q) : s1_q;
	assign sq_start  = (state_q == S_P_I) && (i_q == n_q);

	rsmv_div #(.NW(RW), .DW(S1W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	rsmv_sqrt #(.VW(VW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(vsum_q),
		.done(sq_done), .root(sq_root)
	);

	always_ff @(posedge clk) begin
		if (load_we) begin
			up_mem[cnt_q[AW-1:0]] <= in_ch.data.upload_rate;
			dn_mem[cnt_q[AW-1:0]] <= in_ch.data.download_rate;
		end
		if (rt_we) begin
			rt_mem[k_q[AW-1:0]] <= div_quo;
		end
		up_rd_q <= up_mem[rd_addr];
		dn_rd_q <= dn_mem[rd_addr];
		rt_rd_q <= rt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_count_q <= rsmv_pkg::PEER_COUNT_RST;
			floor_q      <= rsmv_pkg::RATE_FLOOR_RST;
		end else if (wr_en) begin
			case (wr_index)
				rsmv_pkg::REG_PEER_COUNT: peer_count_q <= wr_data[rsmv_pkg::CNT_W-1:0];
				rsmv_pkg::REG_RATE_FLOOR: floor_q      <= wr_data[RTW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_UP;
			cnt_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			len_q       <= '0;
			lt_q        <= '0;
			le_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (load_we) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (in_ch.data.last_item) begin
							n_q     <= load_we ? cnt_q + 1'b1 : cnt_q;
							k_q     <= '0;
							i_q     <= '0;
							state_q <= S_R_RD;
						end
					end
				end
				S_R_RD: begin
					if (i_q == n_q) begin
						sel_q   <= SEL_UP;
						len_q   <= n_q;
						i_q     <= '0;
						lo_q    <= '0;
						hi_q    <= '0;
						state_q <= S_M_CAND;
					end else begin
						state_q <= S_R_CHK;
					end
				end
				S_R_CHK: begin
					if (dn_rd_q > floor_q) begin
						state_q <= S_R_WAIT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_R_RD;
					end
				end
				S_R_WAIT: begin
					if (div_done) begin
						k_q     <= k_q + 1'b1;
						i_q     <= i_q + 1'b1;
						state_q <= S_R_RD;
					end
				end
				S_M_CAND: begin
					if (i_q == len_q) begin
						i_q  <= '0;
						lo_q <= '0;
						hi_q <= '0;
						case (sel_q)
							SEL_UP: begin
								res_up_q <= med;
								sel_q    <= SEL_DN;
								len_q    <= n_q;
								state_q  <= S_M_CAND;
							end
							SEL_DN: begin
								res_dn_q <= med;
								sel_q    <= SEL_RT;
								len_q    <= k_q;
								state_q  <= S_M_CAND;
							end
							default: begin
								res_rt_q <= med;
								s1_q     <= '0;
								if (n_q >= CW'(2)) begin
									state_q <= S_V_RD;
								end else begin
									res_var_q <= '0;
									state_q   <= S_DONE;
								end
							end
						endcase
					end else begin
						state_q <= S_M_CLOAD;
					end
				end
				S_M_CLOAD: begin
					x_q     <= rd_sel;
					j_q     <= '0;
					lt_q    <= '0;
					le_q    <= '0;
					state_q <= S_M_RD;
				end
				S_M_RD: begin
					if (j_q == len_q) begin
						// candidate holds a wanted rank when lt <= rank < le
						if (lt_q <= k1 && k1 < le_q) begin
							lo_q <= x_q;
						end
						if (lt_q <= k2 && k2 < le_q) begin
							hi_q <= x_q;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_M_CAND;
					end else begin
						state_q <= S_M_CMP;
					end
				end
				S_M_CMP: begin
					if (rd_sel < x_q) begin
						lt_q <= lt_q + 1'b1;
					end
					if (rd_sel <= x_q) begin
						le_q <= le_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_M_RD;
				end
				S_V_RD: begin
					state_q <= (i_q == n_q) ? S_V_CHK : S_V_ADD;
				end
				S_V_ADD: begin
					s1_q    <= s1_q + S1W'(dn_rd_q);
					i_q     <= i_q + 1'b1;
					state_q <= S_V_RD;
				end
				S_V_CHK: begin
					if (s1_q <= floor_n) begin
						res_var_q <= '0;
						state_q   <= S_DONE;
					end else begin
						i_q     <= '0;
						vsum_q  <= '0;
						state_q <= S_P_I;
					end
				end
				S_P_I: begin
					state_q <= (i_q == n_q) ? S_SQ_WAIT : S_P_ILOAD;
				end
				S_P_ILOAD: begin
					x_q     <= dn_rd_q;
					j_q     <= i_q + 1'b1;
					state_q <= S_P_RD;
				end
				S_P_RD: begin
					if (j_q == n_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_P_I;
					end else begin
						state_q <= S_P_MUL;
					end
				end
				S_P_MUL: begin
					// n*sum(d^2) - sum(d)^2 is the sum of squared pair differences
					prod_q  <= diff * diff;
					j_q     <= j_q + 1'b1;
					state_q <= S_P_ACC;
				end
				S_P_ACC: begin
					vsum_q  <= vsum_q + VW'(prod_q);
					state_q <= S_P_RD;
				end
				S_SQ_WAIT: begin
					if (sq_done) begin
						state_q <= S_DV_WAIT;
					end
				end
				S_DV_WAIT: begin
					if (div_done) begin
						res_var_q <= div_quo;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (can_load) begin
						out_q.median_upload   <= res_up_q;
						out_q.median_download <= res_dn_q;
						out_q.median_ratio    <= res_rt_q;
						out_q.variation       <= res_var_q;
						out_q.variation_valid <= (n_q >= CW'(2));
						out_q.item_count      <= rsmv_pkg::CNT_W'(n_q);
						out_q.set_ready       <= (32'(n_q) >= 32'(peer_count_q));
						out_valid_q           <= 1'b1;
						cnt_q                 <= '0;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("store fill count beyond capacity");

	a_ratio_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (k_q <= n_q))
		else $error("more ratios than held words");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_RD) |-> (lt_q <= le_q))
		else $error("rank counts out of order");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ch.ready) |=> (state_q == S_DONE))
		else $error("result left before output register was free");
`endif

endmodule

### bench/tb_pkg.sv
// Testbench helpers: statistics predictor for the rate set block.
`timescale 1ns / 1ps
package tb_pkg;
	import rsmv_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam logic [23:0] FULL_SCALE = 24'hFFFFFF;

	typedef logic [23:0] rate_t;

	// Median of the first n entries (sorted in place); truncating average for even n.
	function automatic rate_t median_rates(ref rate_t v[STORE_DEPTH], input int n);
		rate_t x;
		int j;
		logic [24:0] s;
		if (n == 0) return '0;
		for (int i = 1; i < n; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		if (n % 2 == 0) begin
			s = {1'b0, v[n/2-1]} + {1'b0, v[n/2]};
			return s[24:1];
		end
		return v[n/2];
	endfunction

	// Coefficient of variation in Q8.16: largest q with (q*S1)^2 <= 2^32*(n*S2 - S1^2).
	function automatic rate_t download_spread(const ref rate_t d[STORE_DEPTH], input int n,
			input rate_t floor_rate);
		logic [63:0] s1, s2;
		logic [127:0] var_scaled, t;
		logic [23:0] q, c;
		s1 = 0;
		s2 = 0;
		for (int i = 0; i < n; i++) begin
			s1 += 64'(d[i]);
			s2 += 64'(d[i]) * 64'(d[i]);
		end
		if (s1 <= 64'(floor_rate) * 64'(n)) return '0;
		var_scaled = (128'(s2) * 128'(n) - 128'(s1) * 128'(s1)) << 32;
		q = 0;
		for (int b = 23; b >= 0; b--) begin
			c = q | (24'd1 << b);
			t = (128'(c) * 128'(s1)) * (128'(c) * 128'(s1));
			if (t <= var_scaled) q = c;
		end
		return q;
	endfunction

	function automatic out_item_t compute_set_stats(const ref rate_t up[STORE_DEPTH],
			const ref rate_t dn[STORE_DEPTH], input int n, input rate_t floor_rate,
			input logic [6:0] peer_need);
		out_item_t r;
		rate_t tmp[STORE_DEPTH];
		logic [39:0] num;
		int k;
		tmp = up;
		r.median_upload = median_rates(tmp, n);
		tmp = dn;
		r.median_download = median_rates(tmp, n);
		k = 0;
		for (int i = 0; i < n; i++) begin
			if (dn[i] > floor_rate) begin
				num = {up[i], 16'd0} / 40'(dn[i]);
				tmp[k++] = (num > 40'(FULL_SCALE)) ? FULL_SCALE : num[23:0];
			end
		end
		r.median_ratio = median_rates(tmp, k);
		r.variation = (n >= 2) ? download_spread(dn, n, floor_rate) : '0;
		r.variation_valid = (n >= 2);
		r.item_count = 7'(n);
		r.set_ready = (n >= int'(peer_need));
		return r;
	endfunction
endpackage

### bench/tb_top.sv
// Top-level testbench of the rate set median and variation block.
`timescale 1ns / 1ps
module tb_top;
	import rsmv_pkg::*;
	import tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1950;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [CFG_W-1:0] wr_data;

	rsmv_in_if in_ch();
	rsmv_out_if out_ch();

	rate_set_median_and_variation dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	typedef struct {
		in_item_t word;
		logic has_expect;
		out_item_t expect_word;
	} stim_row_t;

	// Predictor state
	rate_t up_store[STORE_DEPTH];
	rate_t dn_store[STORE_DEPTH];
	int held;
	rate_t cfg_floor;
	logic [6:0] cfg_peer_count;

	out_item_t expected_stats[$];
	int fail_count;
	int sets_done;
	int words_sent;
	int idle_cycles;
	bit sink_idle_on;
	bit source_idle_on;
	bit hold_off_req;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic stim_row_t plain_row(input in_item_t w);
		stim_row_t r;
		r.word = w;
		r.has_expect = 0;
		r.expect_word = '0;
		return r;
	endfunction

	// Record an accepted word in the predictor.
	function automatic void absorb_word(input in_item_t w);
		if (held < STORE_DEPTH) begin
			up_store[held] = w.upload_rate;
			dn_store[held] = w.download_rate;
			held++;
		end
		if (w.last_item) begin
			expected_stats.insert(expected_stats.size(), compute_set_stats(up_store,
				dn_store, held, cfg_floor, cfg_peer_count));
			held = 0;
		end
	endfunction

	task automatic send_word(input in_item_t w);
		in_ch.data <= w;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		absorb_word(w);
		words_sent++;
		if (source_idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_PEER_COUNT) cfg_peer_count = val[6:0];
		else cfg_floor = val;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic rate_t rand_rate();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FULL_SCALE;
			2: return 24'($urandom_range(0, 64));
			3: return 24'($urandom_range(1024, 200000));
			default: return 24'($urandom);
		endcase
	endfunction

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected result", out_ch.data.median_upload, '0);
			end else begin
				want = expected_stats.pop_front();
				sets_done++;
				if (out_ch.data.median_upload !== want.median_upload)
					report_mismatch("median_upload", out_ch.data.median_upload,
						want.median_upload);
				if (out_ch.data.median_download !== want.median_download)
					report_mismatch("median_download", out_ch.data.median_download,
						want.median_download);
				if (out_ch.data.median_ratio !== want.median_ratio)
					report_mismatch("median_ratio", out_ch.data.median_ratio,
						want.median_ratio);
				if (out_ch.data.variation !== want.variation)
					report_mismatch("variation", out_ch.data.variation, want.variation);
				if (out_ch.data.variation_valid !== want.variation_valid)
					report_mismatch("variation_valid", 24'(out_ch.data.variation_valid),
						24'(want.variation_valid));
				if (out_ch.data.item_count !== want.item_count)
					report_mismatch("item_count", 24'(out_ch.data.item_count),
						24'(want.item_count));
				if (out_ch.data.set_ready !== want.set_ready)
					report_mismatch("set_ready", 24'(out_ch.data.set_ready),
						24'(want.set_ready));
			end
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				out_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off_req = 0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog on cycles without any accepted word or result while work is pending
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !in_ch.valid
				&& expected_stats.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired");
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		in_item_t w;
		int set_len;
		logic [6:0] peer_opts[4];
		rate_t floor_opts[4];
		rate_t chk_up[STORE_DEPTH];
		rate_t chk_dn[STORE_DEPTH];

		peer_opts = '{7'd0, 7'd64, 7'd2, 7'd3};
		floor_opts = '{24'd0, 24'hFFFFFF, 24'd512, 24'd10};
		arst_n = 0;
		wr_en = 0;
		wr_index = 0;
		wr_data = '0;
		in_ch.valid = 0;
		in_ch.data = '0;
		held = 0;
		cfg_floor = RATE_FLOOR_RST;
		cfg_peer_count = PEER_COUNT_RST;
		fail_count = 0;
		sets_done = 0;
		words_sent = 0;
		idle_cycles = 0;
		sink_idle_on = 1;
		source_idle_on = 1;
		hold_off_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table; typed expectations only where obvious.
		row.has_expect = 1;
		row.word = '{24'd5000, 24'd0, 1'b1};
		row.expect_word = '{24'd5000, 24'd0, 24'd0, 24'd0, 1'b0, 7'd1, 1'b0};
		rows.insert(rows.size(), row);
		rows.insert(rows.size(), plain_row('{FULL_SCALE, FULL_SCALE, 1'b0}));
		rows.insert(rows.size(), plain_row('{FULL_SCALE, 24'd11, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'd0, FULL_SCALE, 1'b1}));
		rows.insert(rows.size(), plain_row('{24'd0, 24'd0, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'd0, 24'd0, 1'b1}));
		rows.insert(rows.size(), plain_row('{24'd1024, 24'd2048, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'd3072, 24'd2048, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'd2048, 24'd4096, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'd7, 24'd10, 1'b1}));
		rows.insert(rows.size(), plain_row('{24'hAAAAAA, 24'h555555, 1'b0}));
		rows.insert(rows.size(), plain_row('{24'h555555, 24'hAAAAAA, 1'b1}));
		foreach (rows[i]) begin
			send_word(rows[i].word);
			if (rows[i].has_expect) begin
				drain();
				if (sets_done == 0) report_mismatch("directed row", 24'(i), '0);
			end
		end
		drain();
		// Hand-typed first row cross-checked against predictor at the same point
		chk_up = '{default:0};
		chk_dn = '{default:0};
		chk_up[0] = 24'd5000;
		if (compute_set_stats(chk_up, chk_dn, 1, RATE_FLOOR_RST, PEER_COUNT_RST)
				!== rows[0].expect_word)
			report_mismatch("directed expectation", '0, '0);

		// Overflow: fill beyond capacity, last word lands on a full store.
		write_reg(REG_PEER_COUNT, 7'd64);
		write_reg(REG_RATE_FLOOR, 24'd0);
		for (int i = 0; i < 70; i++) begin
			w.upload_rate = rand_rate();
			w.download_rate = rand_rate();
			w.last_item = (i == 69);
			send_word(w);
		end
		drain();

		// Pressure: receiver holds off while sets keep coming.
		hold_off_req = 1;
		for (int s = 0; s < 4; s++)
			for (int i = 0; i < 3; i++) begin
				w.upload_rate = rand_rate();
				w.download_rate = rand_rate();
				w.last_item = (i == 2);
				send_word(w);
			end
		drain();

		// Random sets over several register settings; quiet tail at the end.
		while (words_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				write_reg(REG_PEER_COUNT, peer_opts[$urandom_range(0, 3)]);
				write_reg(REG_RATE_FLOOR, $urandom_range(0, 1) ? floor_opts[$urandom_range(0, 3)]
					: rand_rate());
			end
			if (words_sent > RANDOM_ITEMS - 200) begin
				sink_idle_on = 0;
				source_idle_on = 0;
			end
			set_len = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 68)
				: $urandom_range(1, 12);
			for (int i = 0; i < set_len; i++) begin
				w.upload_rate = rand_rate();
				w.download_rate = ($urandom_range(0, 3) == 0) ? rand_rate()
					: 24'($urandom_range(900, 1200));
				w.last_item = (i == set_len - 1);
				send_word(w);
			end
		end
		drain();
		repeat (200) @(posedge clk);

		$display("Sent %0d measurement words, checked %0d result sets", words_sent, sets_done);
		$display("Covered overflow, empty-ratio sets, zero and full-scale floors, long stall");
		if (fail_count == 0 && expected_stats.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### filelist.f
rtl/core/rsmv_pkg.sv
rtl/core/rsmv_if.sv
rtl/core/rsmv_div.sv
rtl/core/rsmv_sqrt.sv
rtl/core/rate_set_median_and_variation.sv
bench/tb_pkg.sv
bench/tb_top.sv
